### hw/rtl/cpo_pkg.sv
// ----------------------------------------------------------------------------
// cpo_pkg
// shared stage type and step counts for the cylinder push-out pipeline
// ----------------------------------------------------------------------------
package cpo_pkg;

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 34;

    typedef struct packed {
        logic        vld;
        logic        hit;
        logic        zero;
        logic        sgx;
        logic        sgz;
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] bz;
        logic [31:0] mx;
        logic [31:0] mz;
        logic [31:0] r;
        logic [63:0] rr;
        logic [63:0] sx;
        logic [63:0] sz;
        logic [63:0] s;
        logic [34:0] sr_rem;
        logic [31:0] d;
        logic [32:0] p;
        logic [63:0] nx;
        logic [63:0] nz;
        logic [31:0] remx;
        logic [31:0] remz;
        logic [33:0] qx;
        logic [33:0] qz;
    } t_pl;

endpackage

### hw/rtl/cylinder_cylinder_push_out_unit.sv
// ----------------------------------------------------------------------------
// cylinder_cylinder_push_out_unit
// resolves overlap of two upright cylinders by pushing B out in XZ
// ----------------------------------------------------------------------------
// Fully pipelined: one pair is taken every cycle unless the output stalls.
// The stages are r_s1 to r_s3, a chain of 32 square-root cells (one root bit
// each), r_s4 to r_s6, a chain of 34 divider cells (one quotient bit each)
// and the output register. The whole pipeline advances together and halts
// only while a finished result waits at the output.
module cylinder_cylinder_push_out_unit import cpo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_a_x,
    input  logic [31:0] i_a_y,
    input  logic [31:0] i_a_z,
    input  logic [30:0] i_a_radius,
    input  logic [30:0] i_a_height,
    input  logic [31:0] i_b_x,
    input  logic [31:0] i_b_y,
    input  logic [31:0] i_b_z,
    input  logic [30:0] i_b_radius,
    input  logic [30:0] i_b_height,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_hit,
    output logic [31:0] o_new_b_x,
    output logic [31:0] o_new_b_y,
    output logic [31:0] o_new_b_z
);

    logic ce;
    t_pl  r_s1, n_s1, r_s2, n_s2, r_s3, n_s3;
    t_pl  r_s4, n_s4, r_s5, n_s5, r_s6, n_s6;
    t_pl  sq [SQ_STEPS+1];
    t_pl  dq [DIV_STEPS+1];

    logic        r_vld, r_hit;
    logic [31:0] r_x, r_y, r_z;

    assign ce      = !r_vld || i_ready;
    assign o_ready = ce;

    // geometry and distance deltas
    logic signed [33:0] ay, by, ah, bh;
    logic signed [32:0] dx, dz;
    logic        [32:0] amx, amz;
    always_comb begin
        ay  = {{2{i_a_y[31]}}, i_a_y};
        by  = {{2{i_b_y[31]}}, i_b_y};
        ah  = {3'b000, i_a_height};
        bh  = {3'b000, i_b_height};
        dx  = $signed({i_b_x[31], i_b_x}) - $signed({i_a_x[31], i_a_x});
        dz  = $signed({i_b_z[31], i_b_z}) - $signed({i_a_z[31], i_a_z});
        amx = dx[32] ? 33'(-dx) : 33'(dx);
        amz = dz[32] ? 33'(-dz) : 33'(dz);
        n_s1     = '0;
        n_s1.vld = i_valid;
        n_s1.bx  = i_b_x;
        n_s1.by  = i_b_y;
        n_s1.bz  = i_b_z;
        n_s1.sgx = dx[32];
        n_s1.sgz = dz[32];
        n_s1.mx  = amx[31:0];
        n_s1.mz  = amz[31:0];
        n_s1.r   = {1'b0, i_a_radius} + {1'b0, i_b_radius};
        n_s1.hit = !((ay > by + bh) || (ay + ah < by)) &&
                   !(amx > {1'b0, n_s1.r}) && !(amz > {1'b0, n_s1.r});
    end

    // squares
    always_comb begin
        n_s2    = r_s1;
        n_s2.sx = r_s1.mx * r_s1.mx;
        n_s2.sz = r_s1.mz * r_s1.mz;
        n_s2.rr = r_s1.r * r_s1.r;
    end

    // range test against the squared radius sum
    logic [64:0] s65;
    always_comb begin
        s65         = {1'b0, r_s2.sx} + {1'b0, r_s2.sz};
        n_s3        = r_s2;
        n_s3.hit    = r_s2.hit && (s65 <= {1'b0, r_s2.rr});
        n_s3.zero   = (s65 == 65'd0);
        n_s3.s      = s65[63:0];
        n_s3.sr_rem = '0;
        n_s3.d      = '0;
    end

    assign sq[0] = r_s3;
    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
        cpo_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_d     (sq[g]),
            .o_q     (sq[g+1])
        );
    end

    // push distance
    always_comb begin
        n_s4   = sq[SQ_STEPS];
        n_s4.p = {1'b0, sq[SQ_STEPS].r} - {1'b0, sq[SQ_STEPS].d};
    end

    logic [64:0] px, pz;
    always_comb begin
        px      = r_s4.mx * r_s4.p;
        pz      = r_s4.mz * r_s4.p;
        n_s5    = r_s4;
        n_s5.nx = px[63:0];
        n_s5.nz = pz[63:0];
    end

    // rounding bias, then split numerator for the divider
    logic [63:0] ux, uz;
    always_comb begin
        ux        = r_s5.nx + {33'd0, r_s5.d[31:1]};
        uz        = r_s5.nz + {33'd0, r_s5.d[31:1]};
        n_s6      = r_s5;
        n_s6.remx = {2'd0, ux[63:34]};
        n_s6.remz = {2'd0, uz[63:34]};
        n_s6.nx   = {ux[33:0], 30'd0};
        n_s6.nz   = {uz[33:0], 30'd0};
        n_s6.qx   = '0;
        n_s6.qz   = '0;
    end

    assign dq[0] = r_s6;
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        cpo_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_d     (dq[g]),
            .o_q     (dq[g+1])
        );
    end

    // apply offsets with saturation
    t_pl                fin;
    logic signed [34:0] ox, oz, sumx, sumz;
    logic        [31:0] n_x, n_z;
    logic               mv;
    always_comb begin
        fin  = dq[DIV_STEPS];
        mv   = fin.hit && !fin.zero;
        ox   = fin.sgx ? -$signed({1'b0, fin.qx}) : $signed({1'b0, fin.qx});
        oz   = fin.sgz ? -$signed({1'b0, fin.qz}) : $signed({1'b0, fin.qz});
        sumx = $signed({{3{fin.bx[31]}}, fin.bx}) + ox;
        sumz = $signed({{3{fin.bz[31]}}, fin.bz}) + oz;
        if (sumx > 35'sh0_7FFF_FFFF) begin
            n_x = 32'h7FFF_FFFF;
        end else if (sumx < -35'sh0_8000_0000) begin
            n_x = 32'h8000_0000;
        end else begin
            n_x = sumx[31:0];
        end
        if (sumz > 35'sh0_7FFF_FFFF) begin
            n_z = 32'h7FFF_FFFF;
        end else if (sumz < -35'sh0_8000_0000) begin
            n_z = 32'h8000_0000;
        end else begin
            n_z = sumz[31:0];
        end
        if (!mv) begin
            n_x = fin.bx;
            n_z = fin.bz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
            r_s3.vld <= 1'b0;
            r_s4.vld <= 1'b0;
            r_s5.vld <= 1'b0;
            r_s6.vld <= 1'b0;
            r_vld    <= 1'b0;
        end else if (ce) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_s3  <= n_s3;
            r_s4  <= n_s4;
            r_s5  <= n_s5;
            r_s6  <= n_s6;
            r_vld <= fin.vld;
            r_hit <= fin.hit;
            r_x   <= n_x;
            r_y   <= fin.by;
            r_z   <= n_z;
        end
    end

    assign o_valid   = r_vld;
    assign o_hit     = r_hit;
    assign o_new_b_x = r_x;
    assign o_new_b_y = r_y;
    assign o_new_b_z = r_z;

endmodule

### hw/rtl/cpo_sqrt_cell.sv
// ----------------------------------------------------------------------------
// cpo_sqrt_cell
// one digit step of the integer square root, registered
// ----------------------------------------------------------------------------
module cpo_sqrt_cell import cpo_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_ce,
    input  t_pl  i_d,
    output t_pl  o_q
);

    t_pl         r_q;
    t_pl         n_q;
    logic [34:0] trial;
    logic [34:0] tst;
    logic        ge;

    always_comb begin
        trial      = {i_d.sr_rem[32:0], i_d.s[63:62]};
        tst        = {1'b0, i_d.d, 2'b01};
        ge         = (trial >= tst);
        n_q        = i_d;
        n_q.sr_rem = ge ? (trial - tst) : trial;
        n_q.d      = {i_d.d[30:0], ge};
        n_q.s      = {i_d.s[61:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else if (i_ce) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

### hw/rtl/cpo_div_cell.sv
// ----------------------------------------------------------------------------
// cpo_div_cell
// one restoring division step for both x and z quotients, registered
// ----------------------------------------------------------------------------
module cpo_div_cell import cpo_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_ce,
    input  t_pl  i_d,
    output t_pl  o_q
);

    t_pl         r_q;
    t_pl         n_q;
    logic [32:0] tx;
    logic [32:0] tz;
    logic [32:0] dv;
    logic [32:0] dfx;
    logic [32:0] dfz;
    logic        gx;
    logic        gz;

    always_comb begin
        dv       = {1'b0, i_d.d};
        tx       = {i_d.remx, i_d.nx[63]};
        tz       = {i_d.remz, i_d.nz[63]};
        gx       = (tx >= dv);
        gz       = (tz >= dv);
        dfx      = tx - dv;
        dfz      = tz - dv;
        n_q      = i_d;
        n_q.remx = gx ? dfx[31:0] : tx[31:0];
        n_q.remz = gz ? dfz[31:0] : tz[31:0];
        n_q.qx   = {i_d.qx[32:0], gx};
        n_q.qz   = {i_d.qz[32:0], gz};
        n_q.nx   = {i_d.nx[62:0], 1'b0};
        n_q.nz   = {i_d.nz[62:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else if (i_ce) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the cylinder push-out pipeline against a behavioral predictor, with
// directed corner pairs, random hits and misses, and random stalls on both
// sides
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic        hit;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_res;

    localparam int LATENCY = 73;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [31:0] i_a_x = 0, i_a_y = 0, i_a_z = 0;
    logic [30:0] i_a_radius = 0, i_a_height = 0;
    logic [31:0] i_b_x = 0, i_b_y = 0, i_b_z = 0;
    logic [30:0] i_b_radius = 0, i_b_height = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic        o_hit;
    logic [31:0] o_new_b_x, o_new_b_y, o_new_b_z;

    t_res pending_pushes[$];
    int   errors = 0;
    int   send_idle = 0;
    int   recv_idle = 0;
    int   hold_off = 0;

    always #5 i_clk = ~i_clk;

    cylinder_cylinder_push_out_unit DUT (.*);

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint push_offset(longint dl, logic [63:0] p, logic [63:0] d);
        logic [63:0] m;
        logic [63:0] q;
        m = (dl < 0) ? -dl : dl;
        m = m * p;
        q = (m + d / 2) / d;
        return (dl < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
        if (v < -64'sh80000000) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic t_res resolve_pair(logic [31:0] ax_, logic [31:0] ay_, logic [31:0] az_,
            logic [30:0] ar, logic [30:0] ah, logic [31:0] bx_, logic [31:0] by_,
            logic [31:0] bz_, logic [30:0] br, logic [30:0] bh);
        longint ax, ay, az, bx, by, bz, dx, dz, nx, nz;
        logic [63:0] r, mx, mz, s, d;
        t_res o;
        ax = longint'($signed(ax_)); ay = longint'($signed(ay_));
        az = longint'($signed(az_)); bx = longint'($signed(bx_));
        by = longint'($signed(by_)); bz = longint'($signed(bz_));
        nx = bx; nz = bz;
        o.hit = 1;
        if (ay > by + longint'(bh) || ay + longint'(ah) < by) begin
            o.hit = 0;
        end else begin
            dx = bx - ax; dz = bz - az;
            r = 64'(ar) + 64'(br);
            mx = (dx < 0) ? -dx : dx;
            mz = (dz < 0) ? -dz : dz;
            s = mx * mx + mz * mz;
            if (mx > r || mz > r || s < mx * mx || s > r * r) begin
                o.hit = 0;
            end else if (s != 0) begin
                d = root_floor(s);
                nx = bx + push_offset(dx, r - d, d);
                nz = bz + push_offset(dz, r - d, d);
            end
        end
        o.x = clamp32(nx); o.y = by_; o.z = clamp32(nz);
        return o;
    endfunction

    task automatic send_pair(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
            logic [30:0] ar, logic [30:0] ah, logic [31:0] bx, logic [31:0] by,
            logic [31:0] bz, logic [30:0] br, logic [30:0] bh);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_a_x <= ax; i_a_y <= ay; i_a_z <= az; i_a_radius <= ar; i_a_height <= ah;
        i_b_x <= bx; i_b_y <= by; i_b_z <= bz; i_b_radius <= br; i_b_height <= bh;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_pushes.push_back(resolve_pair(ax, ay, az, ar, ah, bx, by, bz, br, bh));
    endtask

    task automatic send_random(int n);
        logic [31:0] ax, ay, az, bx, by, bz;
        logic [30:0] ar, ah, br, bh;
        int sh;
        repeat (n) begin
            ax = $urandom; ay = $urandom; az = $urandom;
            ar = 31'($urandom); ah = 31'($urandom); br = 31'($urandom);
            bh = 31'($urandom);
            bx = $urandom; by = $urandom; bz = $urandom;
            case ($urandom_range(3))
                0: ;
                1: begin
                    // near pair with comparable sizes, mostly hits
                    sh = $urandom_range(30, 4);
                    ar = ar >> (31 - sh); br = br >> (31 - sh);
                    ah = ah >> (31 - sh); bh = bh >> (31 - sh);
                    bx = ax + ($signed($urandom) >>> (32 - sh));
                    bz = az + ($signed($urandom) >>> (32 - sh));
                    by = ay + ($signed($urandom) >>> (32 - sh));
                end
                default: begin
                    // overlapping spans, random horizontal reach
                    sh = $urandom_range(31, 2);
                    ah = ah | 31'h40000000; by = ay + ($urandom >> 3);
                    bx = ax + ($signed($urandom) >>> (32 - sh));
                    bz = az + ($signed($urandom) >>> (32 - sh));
                end
            endcase
            send_pair(ax, ay, az, ar, ah, bx, by, bz, br, bh);
        end
    endtask

    task automatic drain();
        i_valid <= 0;
        while (pending_pushes.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_corners();
        logic [31:0] mn, mxv;
        mn = 32'h80000000; mxv = 32'h7FFFFFFF;
        send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(0, 0, 0, 100, 100, 0, 0, 0, 100, 100);
        send_pair(0, 0, 0, 100, 10, 50, 11, 0, 100, 10);
        send_pair(0, 0, 0, 100, 10, 50, 10, 0, 100, 10);
        send_pair(0, 20, 0, 100, 10, 50, 10, 0, 100, 10);
        send_pair(0, 21, 0, 100, 10, 50, 10, 0, 100, 10);
        send_pair(0, 0, 0, 3, 5, 3, 0, 4, 2, 5);
        send_pair(0, 0, 0, 3, 5, 4, 0, 4, 2, 5);
        send_pair(10, 0, 10, 5, 5, 7, 0, 6, 5, 5);
        send_pair(mxv, mxv, mxv, '1, '1, mn, mn, mn, '1, '1);
        send_pair(mn, mn, mn, '1, '1, mxv, mxv, mxv, '1, '1);
        send_pair(mxv - 5, 0, 0, '1, '1, mxv, 0, 1, '1, '1);
        send_pair(mn + 5, 0, mn + 9, '1, '1, mn, 0, mn, '1, '1);
        send_pair(0, mn, 0, 10, '1, 0, mxv, 1, 10, 0);
        send_pair(0, mxv, 0, 10, 0, 0, mn, 1, 10, '1);
        send_pair(-1, -1, -1, 1, 1, 0, 0, 0, 1, 1);
        send_pair(0, 0, 0, '1, '1, 32'h55555555, 0, 32'hAAAAAAAA, 31'h2AAAAAAA,
                  31'h55555555);
        drain();
    endtask

    task automatic test_send_heavy();
        send_idle = 75; recv_idle = 12;
        send_random(150);
        drain();
    endtask

    task automatic test_recv_heavy();
        send_idle = 12; recv_idle = 75;
        send_random(150);
        drain();
    endtask

    task automatic test_back_pressure();
        send_idle = 0; recv_idle = 0;
        hold_off = 200;
        send_random(120);
        drain();
    endtask

    task automatic test_full_rate();
        send_idle = 0; recv_idle = 0;
        send_random(200);
        drain();
    endtask

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_pushes.size() == 0) begin
                $display("%0t unexpected item: exp none act %b %h %h %h", $time, o_hit,
                         o_new_b_x, o_new_b_y, o_new_b_z);
                errors++;
            end else begin
                e = pending_pushes.pop_front();
                if (o_hit !== e.hit) begin
                    $display("%0t hit: exp %b act %b", $time, e.hit, o_hit); errors++;
                end
                if (o_new_b_x !== e.x) begin
                    $display("%0t new_b_x: exp %h act %h", $time, e.x, o_new_b_x); errors++;
                end
                if (o_new_b_y !== e.y) begin
                    $display("%0t new_b_y: exp %h act %h", $time, e.y, o_new_b_y); errors++;
                end
                if (o_new_b_z !== e.z) begin
                    $display("%0t new_b_z: exp %h act %h", $time, e.z, o_new_b_z); errors++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_corners();
        test_recv_heavy();
        test_send_heavy();
        test_back_pressure();
        test_full_rate();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0 && pending_pushes.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
